>>> rtl/odometry_frame_fusion_top_assert.svh
// Assertion macros for the odometry frame fusion block.
`ifndef ODOMETRY_FRAME_FUSION_TOP_ASSERT_SVH
`define ODOMETRY_FRAME_FUSION_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define OFF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Consequent checked in the cycle after the antecedent.
`define OFF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

>>> rtl/off_pkg.sv
// ----------------------------------------------------------------------------
// off_pkg
// Types, constants and helper functions shared by the odometry fusion block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package off_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_QPROD,
        ST_ENTRY,
        ST_MAC
    } off_state_t;

    // Request / response tag that travels through the shared multiplier.
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [3:0] tag;
    } off_mreq_t;

    localparam int NUM_QPROD   = 10;
    localparam int NUM_ENTRY   = 9;
    localparam int NUM_MAC     = 18;
    localparam int SPLIT_BITS  = 18;
    localparam int VEC_W       = 36;
    localparam int QPROD_W     = 32;

    // Component index pairs for the quaternion products:
    // xx yy zz ww xy wz xz wy yz wx
    function automatic logic [1:0] prod_a_idx(input logic [3:0] n);
        logic [1:0] r;
        case (n)
            4'd0:    r = 2'd0;
            4'd1:    r = 2'd1;
            4'd2:    r = 2'd2;
            4'd3:    r = 2'd3;
            4'd4:    r = 2'd0;
            4'd5:    r = 2'd3;
            4'd6:    r = 2'd0;
            4'd7:    r = 2'd3;
            4'd8:    r = 2'd1;
            default: r = 2'd3;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] prod_b_idx(input logic [3:0] n);
        logic [1:0] r;
        case (n)
            4'd0:    r = 2'd0;
            4'd1:    r = 2'd1;
            4'd2:    r = 2'd2;
            4'd3:    r = 2'd3;
            4'd4:    r = 2'd1;
            4'd5:    r = 2'd2;
            4'd6:    r = 2'd2;
            4'd7:    r = 2'd1;
            4'd8:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // Negate with saturation of the most negative value.
    function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
        logic signed [15:0] r;
        if (v == 16'sh8000)
            r = 16'sh7fff;
        else
            r = -v;
        return r;
    endfunction

endpackage

>>> rtl/off_mul.sv
// ----------------------------------------------------------------------------
// off_mul
// Shared registered signed multiplier with a tag carried alongside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module off_mul #(
    parameter int AW = 17
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  off_pkg::off_mreq_t          req,
    input  logic signed [AW-1:0]        a,
    input  logic signed [18:0]          b,
    output off_pkg::off_mreq_t          rsp,
    output logic signed [AW+18:0]       p
);

    off_pkg::off_mreq_t      rsp_reg;
    logic signed [AW+18:0]   p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_reg <= '0;
        end
        else
        begin
            rsp_reg <= req;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            p_reg <= a * b;
        end
    end

    assign rsp = rsp_reg;
    assign p   = p_reg;

endmodule

>>> rtl/odometry_frame_fusion_top.sv
// ----------------------------------------------------------------------------
// odometry_frame_fusion_top
// Dead-reckoning fusion of wheel odometry with a remapped camera orientation.
// ----------------------------------------------------------------------------
// A pose item gives its result in the cycle after acceptance.
// An odometry item runs two passes of 10 quaternion products, 9 matrix entry
// roundings and 18 half-width multiply-accumulates on the single shared
// multiplier, each multiply phase followed by a drain of the multiplier.
// One item is in work at a time; input is held off until the result is taken,
// so a new item is accepted only after the previous result has been taken.
// Reset is asynchronous: identity orientation, zero position, first sample set.
`timescale 1ns / 1ps

module odometry_frame_fusion_top #(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w (low bit up)
    input  logic [159:0] s_tdata,
    // command
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // fused_x, fused_y, fused_z, fused_qx, fused_qy, fused_qz, fused_qw
    output logic [159:0] m_tdata
);

    localparam int RW   = 36 - QUAT_FRAC_BITS;
    localparam int AW   = (RW > 17) ? RW : 17;
    localparam int PW   = AW + 19;
    localparam int ACCW = AW + 40;
    localparam int VW   = off_pkg::VEC_W;
    localparam logic signed [15:0] ONE =
        (QUAT_FRAC_BITS >= 15) ? 16'sh7fff : 16'(1 << QUAT_FRAC_BITS);
    localparam logic signed [VW-1:0]   F_HALF   = VW'(1) <<< (QUAT_FRAC_BITS - 1);
    localparam logic signed [ACCW-1:0] A_HALF   = ACCW'(1) <<< (QUAT_FRAC_BITS - 1);
    localparam logic signed [ACCW-1:0] LOC_MAX  = (ACCW'(1) <<< 34) - ACCW'(1);
    localparam logic signed [ACCW-1:0] LOC_MIN  = -(ACCW'(1) <<< 34);
    localparam logic signed [ACCW-1:0] I32_MAX  = ACCW'(32'sh7fffffff);
    localparam logic signed [ACCW-1:0] I32_MIN  = ACCW'(-33'sh80000000);

    off_pkg::off_state_t state_reg, state_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic                stage_reg, stage_next;
    logic                first_reg;
    logic                out_valid_reg;

    logic signed [15:0]        mq_reg       [4];
    logic signed [31:0]        prod_reg     [10];
    logic signed [RW-1:0]      mat_reg      [9];
    logic signed [VW-1:0]      d_reg        [3];
    logic signed [VW-1:0]      loc_reg      [3];
    logic signed [ACCW-1:0]    acc_reg;
    logic signed [31:0]        prev_pos_reg [3];
    logic signed [15:0]        prev_quat_reg[4];
    logic signed [15:0]        cam_now_reg  [4];
    logic signed [15:0]        cam_lat_reg  [4];
    logic signed [31:0]        accum_reg    [3];

    logic                  in_acc;
    logic                  cmd;
    logic signed [31:0]    in_pos [3];
    logic signed [15:0]    in_quat[4];

    logic [1:0]            ia, ib;
    logic [1:0]            m_row, m_k;
    logic                  m_half;
    logic [4:0]            m_rem;
    logic [3:0]            mat_idx;
    logic signed [RW-1:0]  mat_sel;
    logic signed [VW-1:0]  vec_sel;
    off_pkg::off_mreq_t    mreq, mrsp;
    logic signed [AW-1:0]  mul_a;
    logic signed [18:0]    mul_b;
    logic signed [PW-1:0]  mul_p;

    logic signed [VW-1:0]  f_val;
    logic signed [VW-1:0]  f_rnd;
    logic signed [ACCW-1:0] contrib, sum_c, rnd, tot;
    logic signed [ACCW-1:0] loc_sat, tot_sat;

    assign in_acc = s_tvalid && s_tready;
    assign cmd    = s_tuser[0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_pos[i] = s_tdata[32*i +: 32];
        end
        for (int i = 0; i < 4; i++)
        begin
            in_quat[i] = s_tdata[96 + 16*i +: 16];
        end
    end

    // ---- sequencer ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= off_pkg::ST_IDLE;
            cnt_reg   <= '0;
            stage_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            stage_reg <= stage_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 5'd1;
        stage_next = stage_reg;
        case (state_reg)
            off_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (in_acc && cmd)
                begin
                    state_next = off_pkg::ST_QPROD;
                    stage_next = 1'b0;
                end
            end
            off_pkg::ST_QPROD:
            begin
                if (cnt_reg == 5'(off_pkg::NUM_QPROD))
                begin
                    state_next = off_pkg::ST_ENTRY;
                    cnt_next   = '0;
                end
            end
            off_pkg::ST_ENTRY:
            begin
                if (cnt_reg == 5'(off_pkg::NUM_ENTRY - 1))
                begin
                    state_next = off_pkg::ST_MAC;
                    cnt_next   = '0;
                end
            end
            off_pkg::ST_MAC:
            begin
                if (cnt_reg == 5'(off_pkg::NUM_MAC))
                begin
                    cnt_next = '0;
                    if (!stage_reg)
                    begin
                        state_next = off_pkg::ST_QPROD;
                        stage_next = 1'b1;
                    end
                    else
                    begin
                        state_next = off_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = off_pkg::ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // ---- operand selection ----
    always_comb
    begin
        ia = off_pkg::prod_a_idx(cnt_reg[3:0]);
        ib = off_pkg::prod_b_idx(cnt_reg[3:0]);

        if (cnt_reg >= 5'd12)
        begin
            m_row = 2'd2;
            m_rem = cnt_reg - 5'd12;
        end
        else if (cnt_reg >= 5'd6)
        begin
            m_row = 2'd1;
            m_rem = cnt_reg - 5'd6;
        end
        else
        begin
            m_row = 2'd0;
            m_rem = cnt_reg;
        end
        m_k    = m_rem[2:1];
        m_half = m_rem[0];

        // second pass walks the transpose
        if (stage_reg)
            mat_idx = {2'b00, m_k} * 4'd3 + {2'b00, m_row};
        else
            mat_idx = {2'b00, m_row} * 4'd3 + {2'b00, m_k};
        mat_sel = mat_reg[mat_idx];
        vec_sel = stage_reg ? loc_reg[m_k] : d_reg[m_k];

        mreq = '0;
        mul_a = AW'(mq_reg[ia]);
        mul_b = 19'(mq_reg[ib]);
        if (state_reg == off_pkg::ST_QPROD)
        begin
            mreq.valid = (cnt_reg < 5'(off_pkg::NUM_QPROD));
            mreq.tag   = cnt_reg[3:0];
        end
        else if (state_reg == off_pkg::ST_MAC)
        begin
            mreq.valid = (cnt_reg < 5'(off_pkg::NUM_MAC));
            mreq.tag   = {1'b0, m_half, m_row};
            mreq.last  = (m_k == 2'd2) && m_half;
            mul_a      = AW'(mat_sel);
            if (m_half)
                mul_b = 19'($signed(vec_sel[VW-1:off_pkg::SPLIT_BITS]));
            else
                mul_b = {1'b0, vec_sel[off_pkg::SPLIT_BITS-1:0]};
        end
    end

    off_mul #(
        .AW (AW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .a     (mul_a),
        .b     (mul_b),
        .rsp   (mrsp),
        .p     (mul_p)
    );

    // ---- matrix entry from the stored products ----
    // products: 0 xx 1 yy 2 zz 3 ww 4 xy 5 wz 6 xz 7 wy 8 yz 9 wx
    always_comb
    begin
        case (cnt_reg[3:0])
            4'd0: f_val = VW'(prod_reg[3]) + VW'(prod_reg[0]) - VW'(prod_reg[1])
                          - VW'(prod_reg[2]);
            4'd1: f_val = (VW'(prod_reg[4]) + VW'(prod_reg[5])) <<< 1;
            4'd2: f_val = (VW'(prod_reg[6]) - VW'(prod_reg[7])) <<< 1;
            4'd3: f_val = (VW'(prod_reg[4]) - VW'(prod_reg[5])) <<< 1;
            4'd4: f_val = VW'(prod_reg[3]) - VW'(prod_reg[0]) + VW'(prod_reg[1])
                          - VW'(prod_reg[2]);
            4'd5: f_val = (VW'(prod_reg[8]) + VW'(prod_reg[9])) <<< 1;
            4'd6: f_val = (VW'(prod_reg[6]) + VW'(prod_reg[7])) <<< 1;
            4'd7: f_val = (VW'(prod_reg[8]) - VW'(prod_reg[9])) <<< 1;
            default: f_val = VW'(prod_reg[3]) - VW'(prod_reg[0]) - VW'(prod_reg[1])
                             + VW'(prod_reg[2]);
        endcase
        f_rnd = (f_val + F_HALF) >>> QUAT_FRAC_BITS;
    end

    // ---- accumulate, round, saturate ----
    always_comb
    begin
        if (mrsp.tag[2])
            contrib = ACCW'(mul_p) <<< off_pkg::SPLIT_BITS;
        else
            contrib = ACCW'(mul_p);
        sum_c = acc_reg + contrib;
        rnd   = (sum_c + A_HALF) >>> QUAT_FRAC_BITS;
        tot   = ACCW'(accum_reg[mrsp.tag[1:0]]) + rnd;

        if (rnd > LOC_MAX)
            loc_sat = LOC_MAX;
        else if (rnd < LOC_MIN)
            loc_sat = LOC_MIN;
        else
            loc_sat = rnd;

        if (tot > I32_MAX)
            tot_sat = I32_MAX;
        else if (tot < I32_MIN)
            tot_sat = I32_MIN;
        else
            tot_sat = tot;
    end

    // ---- state with defined reset ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                accum_reg[i] <= '0;
                cam_now_reg[i] <= '0;
                cam_lat_reg[i] <= '0;
            end
            cam_now_reg[3] <= ONE;
            cam_lat_reg[3] <= ONE;
        end
        else
        begin
            if (m_tvalid && m_tready)
                out_valid_reg <= 1'b0;

            if (in_acc && !cmd)
            begin
                cam_now_reg[0] <= in_quat[2];
                cam_now_reg[1] <= off_pkg::neg_sat(in_quat[0]);
                cam_now_reg[2] <= off_pkg::neg_sat(in_quat[1]);
                cam_now_reg[3] <= in_quat[3];
                out_valid_reg  <= 1'b1;
            end

            if (state_reg == off_pkg::ST_MAC && stage_reg && mrsp.valid && mrsp.last)
                accum_reg[mrsp.tag[1:0]] <= tot_sat[31:0];

            if (state_reg == off_pkg::ST_MAC && stage_reg
                && cnt_reg == 5'(off_pkg::NUM_MAC))
            begin
                for (int i = 0; i < 4; i++)
                begin
                    cam_lat_reg[i] <= cam_now_reg[i];
                end
                first_reg     <= 1'b0;
                out_valid_reg <= 1'b1;
            end
        end
    end

    // ---- working storage ----
    always_ff @(posedge clk)
    begin
        if (in_acc && cmd)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (first_reg)
                    d_reg[i] <= '0;
                else
                    d_reg[i] <= VW'(in_pos[i]) - VW'(prev_pos_reg[i]);
                prev_pos_reg[i] <= in_pos[i];
            end
            for (int i = 0; i < 4; i++)
            begin
                mq_reg[i]        <= first_reg ? in_quat[i] : prev_quat_reg[i];
                prev_quat_reg[i] <= in_quat[i];
            end
        end

        if (state_reg == off_pkg::ST_QPROD && mrsp.valid)
            prod_reg[mrsp.tag] <= mul_p[31:0];

        if (state_reg == off_pkg::ST_ENTRY)
            mat_reg[cnt_reg[3:0]] <= f_rnd[RW-1:0];

        if (state_reg == off_pkg::ST_ENTRY)
            acc_reg <= '0;

        if (state_reg == off_pkg::ST_MAC && mrsp.valid)
        begin
            if (mrsp.last)
            begin
                acc_reg <= '0;
                if (!stage_reg)
                    loc_reg[mrsp.tag[1:0]] <= loc_sat[VW-1:0];
            end
            else
            begin
                acc_reg <= sum_c;
            end
        end

        // second pass rotates out with the orientation latched last time
        if (state_reg == off_pkg::ST_MAC && !stage_reg
            && cnt_reg == 5'(off_pkg::NUM_MAC))
        begin
            for (int i = 0; i < 4; i++)
            begin
                mq_reg[i] <= cam_lat_reg[i];
            end
        end
    end

    assign s_tready = (state_reg == off_pkg::ST_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {cam_now_reg[3], cam_now_reg[2], cam_now_reg[1], cam_now_reg[0],
                       accum_reg[2], accum_reg[1], accum_reg[0]};

endmodule

>>> rtl/off_chk.sv
// ----------------------------------------------------------------------------
// off_chk
// Port-level checks for the odometry frame fusion block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "odometry_frame_fusion_top_assert.svh"

module off_chk (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [159:0] s_tdata,
    input logic [0:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [159:0] m_tdata
);

    logic pose_acc;

    assign pose_acc = s_tvalid && s_tready && !s_tuser[0];

    `OFF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `OFF_ASSERT_NOW(a_no_accept_pending, m_tvalid, !s_tready)
    `OFF_ASSERT_NEXT(a_pose_w, pose_acc, m_tvalid && (m_tdata[159:144] == $past(s_tdata[159:144])))
    `OFF_ASSERT_NEXT(a_pose_keeps_pos, pose_acc, m_tdata[95:0] == $past(m_tdata[95:0]))

endmodule

bind odometry_frame_fusion_top off_chk u_off_chk (.*);

>>> dv/tb_odometry_frame_fusion_top.sv
// ----------------------------------------------------------------------------
// tb_odometry_frame_fusion_top
// Drives pose and odometry items with random stalls and checks every fused
// result against a bit-exact dead-reckoning predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class fusion_scoreboard;
    localparam int QF = 14;
    logic signed [31:0] prev_pos [3];
    logic signed [15:0] prev_quat [4];
    logic signed [15:0] cam_now [4];
    logic signed [15:0] cam_latched [4];
    logic signed [31:0] accum [3];
    bit                 first_odom;
    logic [159:0]       pending_fused [$];
    int                 errors;

    function new();
        for (int i = 0; i < 3; i++)
        begin
            prev_pos[i] = 0;
            accum[i] = 0;
        end
        for (int i = 0; i < 4; i++)
        begin
            prev_quat[i] = 0;
            cam_now[i] = 0;
            cam_latched[i] = 0;
        end
        cam_now[3] = 16'sd16384;
        cam_latched[3] = 16'sd16384;
        first_odom = 1;
        errors = 0;
    endfunction

    // floor((v + half) / 2^s)
    function automatic longint rnd(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [15:0] negs(logic signed [15:0] v);
        return (v == -16'sd32768) ? 16'sd32767 : -v;
    endfunction

    function automatic void rot_matrix(logic signed [15:0] q [4], output longint r [3][3]);
        longint x, y, z, w;
        longint f [3][3];
        x = q[0]; y = q[1]; z = q[2]; w = q[3];
        f[0][0] = w*w + x*x - y*y - z*z;
        f[0][1] = 2*(x*y + w*z);
        f[0][2] = 2*(x*z - w*y);
        f[1][0] = 2*(x*y - w*z);
        f[1][1] = w*w - x*x + y*y - z*z;
        f[1][2] = 2*(y*z + w*x);
        f[2][0] = 2*(x*z + w*y);
        f[2][1] = 2*(y*z - w*x);
        f[2][2] = w*w - x*x - y*y + z*z;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                r[i][j] = rnd(f[i][j], QF);
    endfunction

    function void note_item(bit odom, logic [159:0] d);
        logic signed [31:0] p [3];
        logic signed [15:0] q [4];
        longint dl [3], loc [3], r [3][3], s, g, lim;
        lim = 64'sd1 <<< 34;
        for (int i = 0; i < 3; i++) p[i] = d[32*i +: 32];
        for (int i = 0; i < 4; i++) q[i] = d[96 + 16*i +: 16];
        if (!odom)
        begin
            cam_now[0] = q[2];
            cam_now[1] = negs(q[0]);
            cam_now[2] = negs(q[1]);
            cam_now[3] = q[3];
        end
        else
        begin
            if (first_odom)
            begin
                prev_pos = p;
                prev_quat = q;
            end
            for (int i = 0; i < 3; i++) dl[i] = longint'(p[i]) - longint'(prev_pos[i]);
            rot_matrix(prev_quat, r);
            for (int i = 0; i < 3; i++)
            begin
                s = r[i][0]*dl[0] + r[i][1]*dl[1] + r[i][2]*dl[2];
                s = rnd(s, QF);
                loc[i] = s < -lim ? -lim : (s > lim - 1 ? lim - 1 : s);
            end
            rot_matrix(cam_latched, r);
            for (int i = 0; i < 3; i++)
            begin
                s = r[0][i]*loc[0] + r[1][i]*loc[1] + r[2][i]*loc[2];
                g = longint'(accum[i]) + rnd(s, QF);
                if (g > 64'sd2147483647) g = 64'sd2147483647;
                if (g < -64'sd2147483648) g = -64'sd2147483648;
                accum[i] = 32'(g);
            end
            prev_pos = p;
            prev_quat = q;
            cam_latched = cam_now;
            first_odom = 0;
        end
        pending_fused.push_back({cam_now[3], cam_now[2], cam_now[1], cam_now[0],
                                 accum[2], accum[1], accum[0]});
    endfunction

    function void check_result(logic [159:0] got);
        logic [159:0] exp_v;
        string names [7] = '{"fused_x", "fused_y", "fused_z", "fused_qx", "fused_qy",
                             "fused_qz", "fused_qw"};
        if (pending_fused.size() == 0)
        begin
            $error("unexpected result %h", got);
            errors++;
            return;
        end
        exp_v = pending_fused.pop_front();
        for (int i = 0; i < 7; i++)
        begin
            int lo, w;
            lo = (i < 3) ? 32*i : 96 + 16*(i - 3);
            w = (i < 3) ? 32 : 16;
            if (((exp_v >> lo) & ((160'd1 << w) - 1)) != ((got >> lo) & ((160'd1 << w) - 1)))
            begin
                $error("%s expected %h actual %h", names[i],
                       (exp_v >> lo) & ((160'd1 << w) - 1),
                       (got >> lo) & ((160'd1 << w) - 1));
                errors++;
            end
        end
    endfunction
endclass

module tb_odometry_frame_fusion_top;
    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [159:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [159:0] m_tdata;
    bit           no_idle = 0;
    fusion_scoreboard fusion_sb;

    odometry_frame_fusion_top dut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // Sink with random stall bursts; check on each accepted result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                fusion_sb.check_result(m_tdata);
        end
    end

    initial
    begin
        int n;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 4);
                m_tready <= 0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1;
        end
    end

    function automatic logic [15:0] rand_quat();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'h8000;
            3: return 16'h7fff;
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom();
            default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    task automatic send_item(bit odom, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [15:0] qx, logic [15:0] qy, logic [15:0] qz,
                             logic [15:0] qw);
        s_tvalid <= 1;
        s_tuser <= odom;
        s_tdata <= {qw, qz, qy, qx, pz, py, px};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        fusion_sb.note_item(odom, {qw, qz, qy, qx, pz, py, px});
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic send_random();
        send_item($urandom_range(0, 2) != 0, rand_pos(), rand_pos(), rand_pos(),
                  rand_quat(), rand_quat(), rand_quat(), rand_quat());
    endtask

    initial
    begin
        int guard;
        fusion_sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // Odometry before any pose, first sample gives zero change.
        send_item(1, 32'h7fffffff, 32'h80000000, 32'h0, 16'h0, 16'h0, 16'h0, 16'sd16384);
        send_item(1, 32'h80000000, 32'h7fffffff, 32'hffffffff, 16'h0, 16'h0, 16'h0, 16'sd16384);
        send_item(1, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'sd16384, 16'h0, 16'h0, 16'h0);
        // Most negative components exercise the saturating negate.
        send_item(0, 0, 0, 0, 16'h8000, 16'h8000, 16'h7fff, 16'h8000);
        send_item(1, 32'h00010000, 32'h0, 32'h0, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_item(0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 16'sd16384, -16'sd16384,
                  16'sd16384, -16'sd16384);
        send_item(1, 32'h80000000, 32'h80000000, 32'h80000000, 16'hffff, 16'hffff,
                  16'hffff, 16'hffff);
        send_item(1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h0, 16'h0, 16'h0, 16'h0);
        send_item(1, 32'h0, 32'h0, 32'h0, 11585, 0, 0, 11585);
        send_item(0, 0, 0, 0, 0, 0, 11585, 11585);
        send_item(1, 32'h00030000, 32'hfffe0000, 32'h00050000, 0, 11585, 0, 11585);
        for (int i = 0; i < 200; i++) send_random();
        // Hold off until the block has drained.
        s_tvalid <= 0;
        while (fusion_sb.pending_fused.size() != 0) @(posedge clk);
        for (int i = 0; i < 190; i++) send_random();
        no_idle = 1;
        for (int i = 0; i < 50; i++) send_random();
        s_tvalid <= 0;
        guard = 0;
        while (fusion_sb.pending_fused.size() != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (100) @(posedge clk);
        if (fusion_sb.errors == 0 && fusion_sb.pending_fused.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end
endmodule

>>> odometry_frame_fusion_top.f
+incdir+rtl
rtl/off_pkg.sv
rtl/off_mul.sv
rtl/odometry_frame_fusion_top.sv
rtl/off_chk.sv
dv/tb_odometry_frame_fusion_top.sv
